FILE: rtl/per_process_message_mailbox_core_assert.svh
// Assertion macros for the mailbox checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef PER_PROCESS_MESSAGE_MAILBOX_CORE_ASSERT_SVH
`define PER_PROCESS_MESSAGE_MAILBOX_CORE_ASSERT_SVH

// Same-cycle implication.
`define MBX_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MBX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ppmb_pkg.sv
// Shared constants, types and helpers for the mailbox.
// No dependencies.
package ppmb_pkg;

    localparam int NUM_PROCS     = 16;
    localparam int QUEUE_DEPTH   = 16;
    localparam int PAYLOAD_WORDS = 6;

    localparam int PID_W    = 16;
    localparam int WORD_W   = 64;
    localparam int QIDX_W   = $clog2(NUM_PROCS);
    localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W   = QIDX_W + SLOT_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int MSG_W    = WORD_W + PID_W + PAYLOAD_WORDS * WORD_W;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_IDX_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // floor(2^32 / NUM_PROCS): quotient estimate is low by at most one
    localparam logic [31:0] PID_RECIP = 32'((64'd1 << 32) / NUM_PROCS);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_DEST = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [PAYLOAD_WORDS-1:0] words_t;

    typedef struct packed {
        logic              is_recv;
        logic              no_dest;
        logic [QIDX_W-1:0] qidx;
        logic [PID_W-1:0]  sender;
        word_t             msg_type;
        words_t            words;
    } cmd_t;

    function automatic logic [QIDX_W-1:0] pid_to_queue(input logic [PID_W-1:0] pid);
        logic [47:0] prod;
        logic [15:0] quot;
        logic [23:0] qn;
        logic [16:0] rem;
        begin
            prod = 48'(pid) * 48'(PID_RECIP);
            quot = prod[47:32];
            qn   = 24'(quot) * 24'(NUM_PROCS);
            rem  = 17'(pid) - 17'(qn);
            if (rem >= 17'(NUM_PROCS))
            begin
                rem = rem - 17'(NUM_PROCS);
            end
            pid_to_queue = QIDX_W'(rem);
        end
    endfunction

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        begin
            if (s == SLOT_W'(QUEUE_DEPTH - 1))
            begin
                next_slot = '0;
            end
            else
            begin
                next_slot = s + SLOT_W'(1);
            end
        end
    endfunction

endpackage

FILE: rtl/ppmb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ppmb_front.sv
// Request front end: classifies a request and folds the pid into a queue index.
// Depends on ppmb_pkg.
module ppmb_front (
    input  logic                         req_type,
    input  logic [ppmb_pkg::PID_W-1:0]   target_pid,
    input  logic [ppmb_pkg::PID_W-1:0]   caller_pid,
    input  logic                         dest_exists,
    input  ppmb_pkg::word_t              msg_type,
    input  ppmb_pkg::words_t             words,
    output ppmb_pkg::cmd_t               cmd
);
    import ppmb_pkg::*;

    logic [PID_W-1:0] sel_pid;

    // receive uses the caller's own queue
    assign sel_pid = req_type ? caller_pid : target_pid;

    always_comb
    begin
        cmd.is_recv  = req_type;
        cmd.no_dest  = !req_type && !dest_exists;
        cmd.qidx     = pid_to_queue(sel_pid);
        cmd.sender   = caller_pid;
        cmd.msg_type = msg_type;
        cmd.words    = words;
    end

endmodule

FILE: rtl/ppmb_cmdq.sv
// Short command queue between front end and back end.
// Depends on ppmb_pkg.
module ppmb_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ppmb_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output ppmb_pkg::cmd_t head
);
    import ppmb_pkg::*;

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg, count_next;

    function automatic logic [CMDQ_IDX_W-1:0] bump(input logic [CMDQ_IDX_W-1:0] p);
        begin
            if (p == CMDQ_IDX_W'(CMDQ_DEPTH - 1))
            begin
                bump = '0;
            end
            else
            begin
                bump = p + CMDQ_IDX_W'(1);
            end
        end
    endfunction

    assign full  = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CMDQ_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CMDQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/ppmb_back.sv
// Back end: per-queue pointers, fill counts, waiting marks, message store, result register.
// Depends on ppmb_pkg and ppmb_ram.
module ppmb_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_empty,
    input  ppmb_pkg::cmd_t             cmd,
    output logic                       cmd_pop,
    output logic                       res_valid,
    input  logic                       res_stall,
    output logic [1:0]                 res_status,
    output logic                       res_wake,
    output logic [ppmb_pkg::MSG_W-1:0] res_msg
);
    import ppmb_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic              state_reg, state_next;
    logic [SLOT_W-1:0] rd_ptr_reg [NUM_PROCS];
    logic [SLOT_W-1:0] wr_ptr_reg [NUM_PROCS];
    logic [FILL_W-1:0] fill_reg   [NUM_PROCS];
    logic [NUM_PROCS-1:0] wait_reg;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    logic              wake_reg, wake_next;
    logic [MSG_W-1:0]  msg_reg, msg_next;

    logic              out_free;
    logic [QIDX_W-1:0] q;
    logic              q_full, q_empty;
    logic              do_send, do_recv;
    logic [MSG_W-1:0]  ram_wdata, ram_rdata;

    assign out_free = !out_valid_reg || !res_stall;
    assign cmd_pop  = (state_reg == S_IDLE) && !cmd_empty && out_free;
    assign q        = cmd.qidx;
    assign q_full   = (fill_reg[q] == FILL_W'(QUEUE_DEPTH));
    assign q_empty  = (fill_reg[q] == '0);
    assign do_send  = cmd_pop && !cmd.is_recv && !cmd.no_dest && !q_full;
    assign do_recv  = cmd_pop && cmd.is_recv && !q_empty;
    assign ram_wdata = {cmd.msg_type, cmd.sender, cmd.words};

    ppmb_ram #(
        .WIDTH (MSG_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (do_send),
        .waddr ({q, wr_ptr_reg[q]}),
        .wdata (ram_wdata),
        .re    (do_recv),
        .raddr ({q, rd_ptr_reg[q]}),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        wake_next      = wake_reg;
        msg_next       = msg_reg;
        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_READ:
            begin
                out_valid_next = 1'b1;
                status_next    = ST_OK;
                wake_next      = 1'b0;
                msg_next       = ram_rdata;
                state_next     = S_IDLE;
            end
            default:
            begin
                if (do_recv)
                begin
                    state_next = S_READ;
                end
                else if (cmd_pop)
                begin
                    out_valid_next = 1'b1;
                    msg_next       = '0;
                    wake_next      = 1'b0;
                    if (cmd.is_recv)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (cmd.no_dest)
                    begin
                        status_next = ST_NO_DEST;
                    end
                    else if (q_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        wake_next   = wait_reg[q];
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            wait_reg      <= '0;
            for (int i = 0; i < NUM_PROCS; i++)
            begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
                fill_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (do_send)
            begin
                wr_ptr_reg[q] <= next_slot(wr_ptr_reg[q]);
                fill_reg[q]   <= fill_reg[q] + FILL_W'(1);
                wait_reg[q]   <= 1'b0;
            end
            else if (do_recv)
            begin
                rd_ptr_reg[q] <= next_slot(rd_ptr_reg[q]);
                fill_reg[q]   <= fill_reg[q] - FILL_W'(1);
            end
            else if (cmd_pop && cmd.is_recv)
            begin
                wait_reg[q] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        wake_reg   <= wake_next;
        msg_reg    <= msg_next;
    end

    assign res_valid  = out_valid_reg;
    assign res_status = status_reg;
    assign res_wake   = wake_reg;
    assign res_msg    = msg_reg;

endmodule

FILE: rtl/per_process_message_mailbox_core.sv
// A send or failed receive passes the command queue and result register; a successful
// receive also passes the registered store read. One request per cycle while out_stall
// is low; a successful receive holds the back end in S_READ for the store read port.
// Reset clears pointers, fill counts, waiting marks and the command queue at once;
// store contents are undefined until written.
// Depends on ppmb_pkg, ppmb_front, ppmb_cmdq, ppmb_back.
module per_process_message_mailbox_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       req_type,
    input  logic [15:0]                target_pid,
    input  logic [15:0]                caller_pid,
    input  logic                       dest_exists,
    input  logic [63:0]                msg_type,
    input  logic [63:0]                payload_0,
    input  logic [63:0]                payload_1,
    input  logic [63:0]                payload_2,
    input  logic [63:0]                payload_3,
    input  logic [63:0]                payload_4,
    input  logic [63:0]                payload_5,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 status,
    output logic                       wake_receiver,
    output logic [63:0]                out_type,
    output logic [15:0]                out_sender,
    output logic [63:0]                out_word_0,
    output logic [63:0]                out_word_1,
    output logic [63:0]                out_word_2,
    output logic [63:0]                out_word_3,
    output logic [63:0]                out_word_4,
    output logic [63:0]                out_word_5
);
    import ppmb_pkg::*;

    words_t           in_words;
    cmd_t             front_cmd, head_cmd;
    logic             q_full, q_empty, q_pop;
    logic [MSG_W-1:0] res_msg;
    words_t           res_words;

    assign in_words = {payload_5, payload_4, payload_3, payload_2, payload_1, payload_0};

    ppmb_front u_front (
        .req_type    (req_type),
        .target_pid  (target_pid),
        .caller_pid  (caller_pid),
        .dest_exists (dest_exists),
        .msg_type    (msg_type),
        .words       (in_words),
        .cmd         (front_cmd)
    );

    assign in_stall = q_full;

    ppmb_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_valid && !q_full),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (head_cmd)
    );

    ppmb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (q_empty),
        .cmd        (head_cmd),
        .cmd_pop    (q_pop),
        .res_valid  (out_valid),
        .res_stall  (out_stall),
        .res_status (status),
        .res_wake   (wake_receiver),
        .res_msg    (res_msg)
    );

    assign out_type   = res_msg[MSG_W-1 -: WORD_W];
    assign out_sender = res_msg[MSG_W-WORD_W-1 -: PID_W];
    assign res_words  = res_msg[PAYLOAD_WORDS*WORD_W-1:0];
    assign out_word_0 = res_words[0];
    assign out_word_1 = res_words[1];
    assign out_word_2 = res_words[2];
    assign out_word_3 = res_words[3];
    assign out_word_4 = res_words[4];
    assign out_word_5 = res_words[5];

endmodule

FILE: rtl/ppmb_chk.sv
// Port-level checker for the mailbox, bound to the top level.
// Depends on per_process_message_mailbox_core_assert.svh and ppmb_pkg.
`include "per_process_message_mailbox_core_assert.svh"
module ppmb_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic        wake_receiver,
    input logic [63:0] out_type,
    input logic [15:0] out_sender,
    input logic [63:0] out_word_0
);
    import ppmb_pkg::*;

    `MBX_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")
    `MBX_ASSERT_IMPLY(a_wake_ok, out_valid && wake_receiver, status == ST_OK, "wake on failed send")
    `MBX_ASSERT_IMPLY(a_fail_zero, out_valid && status != ST_OK, out_type == '0 && out_sender == '0, "failed request carries data")
    `MBX_ASSERT_IMPLY(a_empty_clean, out_valid && status == ST_EMPTY, !wake_receiver && out_word_0 == '0, "empty receive not clean")

endmodule

bind per_process_message_mailbox_core ppmb_chk u_chk (.*);
